// ----- rtl/qhssp_pkg.sv -----
// Package for the quad half-step stepper positioner.
// Holds the shared widths, lane command and status types, state enum and coil table.
// Has no dependencies.
`default_nettype none

package qhssp_pkg;

    localparam int AXIS_COUNT = 4;
    localparam int POS_BITS   = 16;
    localparam int PHASE_BITS = 3;
    localparam int COIL_BITS  = 4;
    localparam int AXIS_BITS  = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

    localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
    localparam logic signed [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};

    typedef logic [AXIS_BITS-1:0] t_axis;

    typedef enum logic {
        HS_TRACK,
        HS_HOMING
    } t_home_state;

    // Command from the homing controller to one lane.
    typedef struct packed {
        logic home_mode;   // homing in progress this tick, no tracking
        logic home_sel;    // this lane takes the homing step
        logic home_up;     // direction of the homing step
        logic home_clear;  // home switch seen, clear the position after the step
    } t_lane_cmd;

    // Status of one lane as it stands before the tick.
    typedef struct packed {
        logic nonzero;
        logic positive;
    } t_lane_stat;

    // Half-step coil sequence.
    function automatic logic [COIL_BITS-1:0] coil_pattern(input logic [PHASE_BITS-1:0] phase);
        logic [COIL_BITS-1:0] pat;
        unique case (phase)
            3'd0:    pat = 4'd1;
            3'd1:    pat = 4'd3;
            3'd2:    pat = 4'd2;
            3'd3:    pat = 4'd6;
            3'd4:    pat = 4'd4;
            3'd5:    pat = 4'd12;
            3'd6:    pat = 4'd8;
            default: pat = 4'd9;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/qhssp_lane.sv -----
// One axis lane: position, phase counter and energised flag of a single stepper.
// Depends on qhssp_pkg.
`default_nettype none

module qhssp_lane (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_en,
    input  wire logic signed [qhssp_pkg::POS_BITS-1:0] i_target,
    input  wire qhssp_pkg::t_lane_cmd               i_cmd,
    output qhssp_pkg::t_lane_stat                   o_stat,
    output logic signed [qhssp_pkg::POS_BITS-1:0]   o_next_position,
    output logic [qhssp_pkg::COIL_BITS-1:0]         o_next_coil
);

    logic signed [qhssp_pkg::POS_BITS-1:0] r_pos, n_pos;
    logic [qhssp_pkg::PHASE_BITS-1:0]      r_phase, n_phase;
    logic                                  r_energized, n_energized;
    logic                                  step;
    logic                                  up;

    always_comb begin
        if (i_cmd.home_mode) begin
            step = i_cmd.home_sel;
            up   = i_cmd.home_up;
        end else begin
            step = (r_pos != i_target);
            up   = (i_target > r_pos);
        end

        n_pos       = r_pos;
        n_phase     = r_phase;
        n_energized = r_energized | step;
        if (step) begin
            if (up) begin
                n_phase = r_phase + 1'b1;
                if (r_pos != qhssp_pkg::POS_MAX) begin
                    n_pos = r_pos + 1'b1;
                end
            end else begin
                n_phase = r_phase - 1'b1;
                if (r_pos != qhssp_pkg::POS_MIN) begin
                    n_pos = r_pos - 1'b1;
                end
            end
        end
        if (i_cmd.home_mode && i_cmd.home_clear) begin
            n_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_phase     <= '0;
            r_energized <= 1'b0;
        end else if (i_en) begin
            r_pos       <= n_pos;
            r_phase     <= n_phase;
            r_energized <= n_energized;
        end
    end

    assign o_stat.nonzero   = (r_pos != '0);
    assign o_stat.positive  = (r_pos != '0) && !r_pos[qhssp_pkg::POS_BITS-1];
    assign o_next_position  = n_pos;
    assign o_next_coil      = n_energized ? qhssp_pkg::coil_pattern(n_phase) : '0;

endmodule

`default_nettype wire

// ----- rtl/qhssp_home.sv -----
// Homing controller: chooses which lane steps during homing and merges lane status.
// Depends on qhssp_pkg.
`default_nettype none

module qhssp_home (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire logic                                         i_en,
    input  wire logic                                         i_zero_request,
    input  wire logic [qhssp_pkg::AXIS_COUNT-1:0]             i_switches,
    input  wire qhssp_pkg::t_lane_stat [qhssp_pkg::AXIS_COUNT-1:0] i_stat,
    output qhssp_pkg::t_lane_cmd [qhssp_pkg::AXIS_COUNT-1:0]  o_cmd,
    output logic                                              o_next_busy
);

    qhssp_pkg::t_home_state r_state, n_state;
    qhssp_pkg::t_axis       r_axis, n_axis;
    logic                   r_dir, n_dir;   // 1 means stepping down

    qhssp_pkg::t_axis first_idx, next_idx, eff_axis;
    logic             first_found, next_found, start, homing, eff_dir, clear;

    // Lowest lane with a nonzero position, and lowest above the current axis.
    always_comb begin
        first_idx   = '0;
        first_found = 1'b0;
        next_idx    = '0;
        next_found  = 1'b0;
        for (int k = qhssp_pkg::AXIS_COUNT - 1; k >= 0; k--) begin
            if (i_stat[k].nonzero) begin
                first_idx   = qhssp_pkg::AXIS_BITS'(k);
                first_found = 1'b1;
            end
        end
        for (int k = qhssp_pkg::AXIS_COUNT - 1; k >= 0; k--) begin
            if (i_stat[k].nonzero && (qhssp_pkg::AXIS_BITS'(k) > eff_axis)) begin
                next_idx   = qhssp_pkg::AXIS_BITS'(k);
                next_found = 1'b1;
            end
        end
    end

    always_comb begin
        start    = (r_state == qhssp_pkg::HS_TRACK) && i_zero_request && first_found;
        homing   = (r_state == qhssp_pkg::HS_HOMING) || start;
        eff_axis = start ? first_idx : r_axis;
        eff_dir  = start ? i_stat[first_idx].positive : r_dir;
        clear    = homing && i_switches[eff_axis];

        n_state = r_state;
        n_axis  = eff_axis;
        n_dir   = eff_dir;
        unique case (r_state)
            qhssp_pkg::HS_TRACK: begin
                if (start) begin
                    n_state = qhssp_pkg::HS_HOMING;
                end
            end
            qhssp_pkg::HS_HOMING: begin
                n_state = qhssp_pkg::HS_HOMING;
            end
            default: begin
                n_state = qhssp_pkg::HS_TRACK;
            end
        endcase
        if (clear) begin
            if (next_found) begin
                n_axis = next_idx;
                n_dir  = i_stat[next_idx].positive;
            end else begin
                n_state = qhssp_pkg::HS_TRACK;
            end
        end

        for (int k = 0; k < qhssp_pkg::AXIS_COUNT; k++) begin
            o_cmd[k].home_mode  = homing;
            o_cmd[k].home_sel   = homing && (eff_axis == qhssp_pkg::AXIS_BITS'(k));
            o_cmd[k].home_up    = !eff_dir;
            o_cmd[k].home_clear = clear && (eff_axis == qhssp_pkg::AXIS_BITS'(k));
        end
        o_next_busy = (n_state == qhssp_pkg::HS_HOMING);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qhssp_pkg::HS_TRACK;
            r_axis  <= '0;
            r_dir   <= 1'b0;
        end else if (i_en) begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_dir   <= n_dir;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/quad_half_step_stepper_positioner_top.sv -----
// Top level of the quad half-step stepper positioner.
// Instantiates four qhssp_lane cores and the qhssp_home controller; uses qhssp_pkg.
//
// Usage. Each request on the input channel (i_valid / o_ready) is one step tick
// carrying four signed target positions, a zero request and four home-switch
// levels. Each request produces exactly one result on the output channel
// (o_valid / i_ready): the packed coil patterns, the homing flag and the four
// positions as they stand after the tick.
//
// The four axes are handled by four lanes side by side, so a whole tick is
// worked out in the cycle in which the request is accepted. The axis state is
// updated at that edge and the result is held in an output register, so the result
// is valid in the next cycle; one request per cycle is taken while the receiver keeps up.
// The only limit on rate is the single output register: a new request is taken
// whenever that register is empty or is being emptied in the same cycle.
//
// When the receiver stalls, the result stays in the output register unchanged
// and o_ready falls, so no further request is taken until the result leaves.
// A synchronous reset (i_rst_n low) clears all positions, phases and energised
// flags, leaves tracking mode active and empties the output register; coil
// patterns read as zero until an axis first steps.
`default_nettype none

module quad_half_step_stepper_positioner_top (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_valid,
    output logic                                             o_ready,
    input  wire logic signed [qhssp_pkg::POS_BITS-1:0]       i_target_a,
    input  wire logic signed [qhssp_pkg::POS_BITS-1:0]       i_target_b,
    input  wire logic signed [qhssp_pkg::POS_BITS-1:0]       i_target_c,
    input  wire logic signed [qhssp_pkg::POS_BITS-1:0]       i_target_d,
    input  wire logic                                        i_zero_request,
    input  wire logic [qhssp_pkg::AXIS_COUNT-1:0]            i_home_switches,
    output logic                                             o_valid,
    input  wire logic                                        i_ready,
    output logic [qhssp_pkg::AXIS_COUNT*qhssp_pkg::COIL_BITS-1:0] o_coil_drive,
    output logic                                             o_homing_busy,
    output logic signed [qhssp_pkg::POS_BITS-1:0]            o_position_a,
    output logic signed [qhssp_pkg::POS_BITS-1:0]            o_position_b,
    output logic signed [qhssp_pkg::POS_BITS-1:0]            o_position_c,
    output logic signed [qhssp_pkg::POS_BITS-1:0]            o_position_d
);

    logic accept;

    logic signed [qhssp_pkg::POS_BITS-1:0] targets  [qhssp_pkg::AXIS_COUNT];
    logic signed [qhssp_pkg::POS_BITS-1:0] next_pos [qhssp_pkg::AXIS_COUNT];
    logic [qhssp_pkg::AXIS_COUNT*qhssp_pkg::COIL_BITS-1:0] next_coils;

    qhssp_pkg::t_lane_cmd  [qhssp_pkg::AXIS_COUNT-1:0] lane_cmd;
    qhssp_pkg::t_lane_stat [qhssp_pkg::AXIS_COUNT-1:0] lane_stat;
    logic                                              next_busy;

    logic                                  r_out_valid;
    logic [qhssp_pkg::AXIS_COUNT*qhssp_pkg::COIL_BITS-1:0] r_coil;
    logic                                  r_busy;
    logic signed [qhssp_pkg::POS_BITS-1:0] r_pos [qhssp_pkg::AXIS_COUNT];

    // The output register is free when empty or when its result leaves now.
    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // Axis k follows its own target k.
    assign targets[0] = i_target_a;
    assign targets[1] = i_target_b;
    assign targets[2] = i_target_c;
    assign targets[3] = i_target_d;

    qhssp_home u_home (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (accept),
        .i_zero_request (i_zero_request),
        .i_switches     (i_home_switches),
        .i_stat         (lane_stat),
        .o_cmd          (lane_cmd),
        .o_next_busy    (next_busy)
    );

    for (genvar k = 0; k < qhssp_pkg::AXIS_COUNT; k++) begin : g_lane
        qhssp_lane u_lane (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_en            (accept),
            .i_target        (targets[k]),
            .i_cmd           (lane_cmd[k]),
            .o_stat          (lane_stat[k]),
            .o_next_position (next_pos[k]),
            .o_next_coil     (next_coils[k*qhssp_pkg::COIL_BITS +: qhssp_pkg::COIL_BITS])
        );
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload, loaded with each accepted request.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_coil <= next_coils;
            r_busy <= next_busy;
            for (int k = 0; k < qhssp_pkg::AXIS_COUNT; k++) begin
                r_pos[k] <= next_pos[k];
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_coil_drive  = r_coil;
    assign o_homing_busy = r_busy;
    assign o_position_a  = r_pos[0];
    assign o_position_b  = r_pos[1];
    assign o_position_c  = r_pos[2];
    assign o_position_d  = r_pos[3];

endmodule

`default_nettype wire

// ----- rtl/qhssp_checker.sv -----
// Port-level checker for the quad half-step stepper positioner, with its bind.
// Depends on qhssp_pkg and quad_half_step_stepper_positioner_top.
`default_nettype none

module qhssp_checker (
    input wire logic                                        i_clk,
    input wire logic                                        i_rst_n,
    input wire logic                                        i_valid,
    input wire logic                                        o_ready,
    input wire logic                                        o_valid,
    input wire logic                                        i_ready,
    input wire logic [qhssp_pkg::AXIS_COUNT*qhssp_pkg::COIL_BITS-1:0] o_coil_drive,
    input wire logic                                        o_homing_busy,
    input wire logic signed [qhssp_pkg::POS_BITS-1:0]       o_position_a,
    input wire logic signed [qhssp_pkg::POS_BITS-1:0]       o_position_b,
    input wire logic signed [qhssp_pkg::POS_BITS-1:0]       o_position_c,
    input wire logic signed [qhssp_pkg::POS_BITS-1:0]       o_position_d
);

    // A stalled result holds its coils, homing flag and positions a and d.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_coil_drive) && $stable(o_homing_busy)
            && $stable(o_position_a) && $stable(o_position_d))
        else $error("stalled result changed");

    // An empty output register always takes a request.
    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("ready low with empty output register");

    // Every accepted request yields a result in the next cycle.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> o_valid)
        else $error("no result one cycle after a request");

    // An axis away from zero has stepped, so its coils are energised.
    a_coil_ab: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_position_a == '0 || o_coil_drive[3:0] != 4'd0)
            && (o_position_b == '0 || o_coil_drive[7:4] != 4'd0))
        else $error("axis off zero with coils dark");

    a_coil_cd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_position_c == '0 || o_coil_drive[11:8] != 4'd0)
            && (o_position_d == '0 || o_coil_drive[15:12] != 4'd0))
        else $error("axis off zero with coils dark");

endmodule

bind quad_half_step_stepper_positioner_top qhssp_checker u_qhssp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_coil_drive  (o_coil_drive),
    .o_homing_busy (o_homing_busy),
    .o_position_a  (o_position_a),
    .o_position_b  (o_position_b),
    .o_position_c  (o_position_c),
    .o_position_d  (o_position_d)
);

`default_nettype wire

// ----- bench/qhssp_positioner_scoreboard_pkg.sv -----
// Scoreboard for the quad half-step stepper positioner bench: own model of the
// four axes and the homing sequence, plus the queue of expected results.
// Depends on qhssp_pkg for widths and position limits.
package qhssp_positioner_scoreboard_pkg;

    import qhssp_pkg::*;

    // One step tick as offered on the input channel.
    typedef struct packed {
        logic [AXIS_COUNT-1:0][POS_BITS-1:0] target;
        logic                                zero_req;
        logic [AXIS_COUNT-1:0]               switches;
    } tick_t;

    // One result as seen on the output channel.
    typedef struct packed {
        logic [AXIS_COUNT*COIL_BITS-1:0]     coil;
        logic                                busy;
        logic [AXIS_COUNT-1:0][POS_BITS-1:0] pos;
    } axis_report_t;

    localparam logic [COIL_BITS-1:0] COIL_SEQUENCE [8] =
        '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

    localparam string AXIS_LETTER [4] = '{"a", "b", "c", "d"};

    class positioner_scoreboard;

        logic signed [POS_BITS-1:0] position [AXIS_COUNT];
        logic [PHASE_BITS-1:0]      phase [AXIS_COUNT];
        bit                         energised [AXIS_COUNT];
        bit                         homing;
        int unsigned                home_axis;
        bit                         home_down;

        axis_report_t expected_results [$];
        int unsigned  mismatches;
        int unsigned  results_checked;
        int unsigned  homings_started;

        function new();
            for (int k = 0; k < AXIS_COUNT; k++) begin
                position[k]  = '0;
                phase[k]     = '0;
                energised[k] = 1'b0;
            end
            homing    = 1'b0;
            home_axis = 0;
            home_down = 1'b0;
        endfunction

        function void step_axis(int unsigned k, bit up);
            if (up) begin
                phase[k] = phase[k] + 1'b1;
                if (position[k] != POS_MAX) position[k] = position[k] + 1'b1;
            end else begin
                phase[k] = phase[k] - 1'b1;
                if (position[k] != POS_MIN) position[k] = position[k] - 1'b1;
            end
            energised[k] = 1'b1;
        endfunction

        function int unsigned first_nonzero(int unsigned from);
            for (int unsigned k = from; k < AXIS_COUNT; k++)
                if (position[k] != 0) return k;
            return AXIS_COUNT;
        endfunction

        function void begin_axis(int unsigned k);
            home_axis = k;
            home_down = (position[k] > 0);
        endfunction

        // Advances the model by one accepted tick and queues the result it causes.
        function void note_tick(tick_t t);
            int unsigned                k;
            int unsigned                n;
            logic signed [POS_BITS-1:0] goal;
            axis_report_t               r;
            if (!homing && t.zero_req) begin
                n = first_nonzero(0);
                if (n < AXIS_COUNT) begin
                    homing = 1'b1;
                    begin_axis(n);
                    homings_started++;
                end
            end
            if (homing) begin
                if (home_axis >= AXIS_COUNT) begin
                    homing = 1'b0;
                end else begin
                    k = home_axis;
                    step_axis(k, !home_down);
                    if (t.switches[k]) begin
                        position[k] = '0;
                        n = first_nonzero(k + 1);
                        if (n < AXIS_COUNT) begin_axis(n);
                        else homing = 1'b0;
                    end
                end
            end else begin
                for (k = 0; k < AXIS_COUNT; k++) begin
                    goal = $signed(t.target[k]);
                    if (position[k] != goal) step_axis(k, goal > position[k]);
                end
            end
            r = '0;
            for (k = 0; k < AXIS_COUNT; k++) begin
                if (energised[k]) r.coil[COIL_BITS*k +: COIL_BITS] = COIL_SEQUENCE[phase[k]];
                r.pos[k] = position[k];
            end
            r.busy = homing;
            expected_results.push_back(r);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            if (mismatches < 100)
                $display("MISMATCH %s: got %0h, expected %0h (result %0d)",
                         what, got, want, results_checked);
            mismatches++;
        endtask

        task check_result(axis_report_t got);
            axis_report_t want;
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected", got.coil, '0);
            end else begin
                want = expected_results.pop_front();
                if (got.coil !== want.coil) report_mismatch("coil_drive", got.coil, want.coil);
                if (got.busy !== want.busy) report_mismatch("homing_busy", got.busy, want.busy);
                for (int k = 0; k < AXIS_COUNT; k++)
                    if (got.pos[k] !== want.pos[k])
                        report_mismatch({"position_", AXIS_LETTER[k]}, got.pos[k], want.pos[k]);
            end
            results_checked++;
        endtask

        function int unsigned pending();
            return expected_results.size();
        endfunction

    endclass

endpackage

// ----- bench/quad_half_step_stepper_positioner_top_test.sv -----
// Self-checking bench for quad_half_step_stepper_positioner_top: directed ticks
// through tracking and homing, then random tracking and homing.
// Depends on qhssp_pkg, qhssp_positioner_scoreboard_pkg and the positioner RTL.
module quad_half_step_stepper_positioner_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import qhssp_pkg::*;
    import qhssp_positioner_scoreboard_pkg::*;

    // Random ticks after the directed part.
    localparam int unsigned RANDOM_TICKS = 1700;
    // Cycles with no request moving on either channel before the run is abandoned.
    localparam int unsigned IDLE_LIMIT   = 3000;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_ready;
    logic signed [POS_BITS-1:0]          i_target_a;
    logic signed [POS_BITS-1:0]          i_target_b;
    logic signed [POS_BITS-1:0]          i_target_c;
    logic signed [POS_BITS-1:0]          i_target_d;
    logic                                i_zero_request;
    logic [AXIS_COUNT-1:0]               i_home_switches;
    logic                                o_valid;
    logic                                i_ready;
    logic [AXIS_COUNT*COIL_BITS-1:0]     o_coil_drive;
    logic                                o_homing_busy;
    logic signed [POS_BITS-1:0]          o_position_a;
    logic signed [POS_BITS-1:0]          o_position_b;
    logic signed [POS_BITS-1:0]          o_position_c;
    logic signed [POS_BITS-1:0]          o_position_d;

    quad_half_step_stepper_positioner_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_target_a      (i_target_a),
        .i_target_b      (i_target_b),
        .i_target_c      (i_target_c),
        .i_target_d      (i_target_d),
        .i_zero_request  (i_zero_request),
        .i_home_switches (i_home_switches),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_coil_drive    (o_coil_drive),
        .o_homing_busy   (o_homing_busy),
        .o_position_a    (o_position_a),
        .o_position_b    (o_position_b),
        .o_position_c    (o_position_c),
        .o_position_d    (o_position_d)
    );

    positioner_scoreboard sb = new();

    int unsigned ticks_sent;
    int unsigned burst_left;
    int unsigned idle_cycles;
    bit          hold_off_go;
    bit          hold_off_done;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Reset is held at the start and never asserted again.
    initial begin
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Sender side. Every task here is entered just after a rising edge and
    // returns just after one, so that each edge sees at most one assignment to
    // i_valid. A request that has been accepted is noted in the scoreboard at
    // the very edge of acceptance, before the next tick is chosen, so the
    // stimulus can steer by the model's view of the axes.
    // ------------------------------------------------------------------------

    task automatic send_tick(input tick_t t);
        i_valid         <= 1'b1;
        i_target_a      <= t.target[0];
        i_target_b      <= t.target[1];
        i_target_c      <= t.target[2];
        i_target_d      <= t.target[3];
        i_zero_request  <= t.zero_req;
        i_home_switches <= t.switches;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        sb.note_tick(t);
        ticks_sent++;
    endtask

    task automatic pause_sender(input int unsigned cycles);
        if (cycles != 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Offers a tick as part of a burst; between bursts the sender goes quiet for
    // a random gap. Now and then a long burst runs with no gap at all.
    task automatic offer(input tick_t t);
        if (burst_left == 0) begin
            if ($urandom_range(0, 9) == 0) begin
                burst_left = $urandom_range(80, 200);
            end else begin
                pause_sender($urandom_range(0, 6));
                burst_left = $urandom_range(1, 24);
            end
        end
        send_tick(t);
        burst_left--;
    endtask

    // Holds off until every expected result has come back.
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic tick_t make_tick(input logic signed [POS_BITS-1:0] a,
                                        input logic signed [POS_BITS-1:0] b,
                                        input logic signed [POS_BITS-1:0] c,
                                        input logic signed [POS_BITS-1:0] d,
                                        input logic req, input logic [AXIS_COUNT-1:0] sw);
        tick_t t;
        t.target[0] = a;
        t.target[1] = b;
        t.target[2] = c;
        t.target[3] = d;
        t.zero_req  = req;
        t.switches  = sw;
        return t;
    endfunction

    // Tracks all four axes to the given targets, one tick at a time.
    task automatic track_to(input logic signed [POS_BITS-1:0] a,
                            input logic signed [POS_BITS-1:0] b,
                            input logic signed [POS_BITS-1:0] c,
                            input logic signed [POS_BITS-1:0] d);
        while (sb.position[0] != a || sb.position[1] != b ||
               sb.position[2] != c || sb.position[3] != d)
            send_tick(make_tick(a, b, c, d, 1'b0, 4'($urandom)));
    endtask

    // Tracking tick: most targets lie a few steps from the present position so
    // that axes reach them and settle; some are anywhere in the 16-bit range.
    function automatic tick_t tracking_tick();
        tick_t t;
        for (int k = 0; k < AXIS_COUNT; k++) begin
            if ($urandom_range(0, 7) == 0)
                t.target[k] = POS_BITS'($urandom);
            else
                t.target[k] = sb.position[k] + POS_BITS'($urandom_range(0, 40)) - POS_BITS'(20);
        end
        t.zero_req = ($urandom_range(0, 23) == 0);
        t.switches = AXIS_COUNT'($urandom);
        return t;
    endfunction

    // Homing tick: targets and the zero request are noise here. The switch of
    // the axis being homed mostly rises near zero, occasionally anywhere, and
    // the other switches are random.
    function automatic tick_t homing_tick();
        tick_t       t;
        int unsigned k;
        t = make_tick(POS_BITS'($urandom), POS_BITS'($urandom), POS_BITS'($urandom),
                      POS_BITS'($urandom), 1'($urandom), AXIS_COUNT'($urandom));
        k = sb.home_axis;
        if (k < AXIS_COUNT) begin
            t.switches[k] = 1'b0;
            if ((sb.position[k] >= -1 && sb.position[k] <= 1 && $urandom_range(0, 1) == 1) ||
                $urandom_range(0, 11) == 0)
                t.switches[k] = 1'b1;
        end
        return t;
    endfunction

    // Main stimulus.
    initial begin
        int unsigned random_sent;
        bit          mid_drain_done;
        i_valid         <= 1'b0;
        i_target_a      <= '0;
        i_target_b      <= '0;
        i_target_c      <= '0;
        i_target_d      <= '0;
        i_zero_request  <= 1'b0;
        i_home_switches <= '0;
        ticks_sent     = 0;
        burst_left     = 0;
        hold_off_go    = 1'b0;
        mid_drain_done = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);

        // Directed part. A first tick with nothing to do shows the coils dark.
        send_tick(make_tick(0, 0, 0, 0, 1'b0, 4'h0));
        // A zero request while every position is 0 does not start homing, so
        // the tick tracks instead; targets at both ends of the range.
        send_tick(make_tick(16'sh7FFF, 16'sh8000, 0, 1, 1'b1, 4'hF));
        send_tick(make_tick(2, -1, 0, 16'sh8000, 1'b0, 4'h0));
        // Homing starts on axis a (positive, so it steps down) on the request
        // tick itself; the targets are extremes and must be ignored.
        send_tick(make_tick(16'sh8000, 16'sh7FFF, -1, 1, 1'b1, 4'h0));
        // A further request during homing is ignored.
        send_tick(make_tick(0, 0, 0, 0, 1'b1, 4'h0));
        // Axis a passes zero without its switch and keeps stepping down.
        send_tick(make_tick(0, 0, 0, 0, 1'b0, 4'h0));
        // Its switch rises with the others' (bar b); a clears and b, which is
        // negative, begins homing upwards.
        send_tick(make_tick(0, 0, 0, 0, 1'b0, 4'b1101));
        send_tick(make_tick(0, 0, 0, 0, 1'b0, 4'b1101));
        // b clears; c and d sit at zero and are skipped, so homing ends here.
        send_tick(make_tick(0, 0, 0, 0, 1'b0, 4'b0010));
        // Tracking resumes on the next tick, each axis on its own target.
        track_to(5, -5, 3, 0);
        // Switches high on the first step of a and b and the second of c.
        send_tick(make_tick(0, 0, 0, 0, 1'b1, 4'b0001));
        send_tick(make_tick(0, 0, 0, 0, 1'b0, 4'b0010));
        send_tick(make_tick(0, 0, 0, 0, 1'b0, 4'b1000));
        send_tick(make_tick(0, 0, 0, 0, 1'b0, 4'b0100));
        drain();

        // Random part: stretches of tracking, each often followed by a full
        // homing sequence with random content.
        random_sent = 0;
        while (random_sent < RANDOM_TICKS) begin
            repeat ($urandom_range(4, 40)) begin
                offer(tracking_tick());
                random_sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
                offer(make_tick(POS_BITS'($urandom), POS_BITS'($urandom),
                                POS_BITS'($urandom), POS_BITS'($urandom),
                                1'b1, AXIS_COUNT'($urandom)));
                random_sent++;
                while (sb.homing) begin
                    offer(homing_tick());
                    random_sent++;
                end
            end
            // Let the receiver hold off for a long stretch while requests keep
            // coming, and once, part way through, let everything drain.
            if (random_sent >= 200) hold_off_go = 1'b1;
            if (random_sent >= 900 && !mid_drain_done) begin
                mid_drain_done = 1'b1;
                drain();
            end
        end

        // Wait for the last results, and then on for any stray one.
        drain();
        repeat (6) @(posedge i_clk);
        $display("Covered %0d ticks and %0d results, with %0d homing sequences,",
                 ticks_sent, sb.results_checked, sb.homings_started);
        $display("random gaps on the input and stalls on the output.");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver side: stretches of steady readiness and of light, random and heavy
    // stalls, plus one long hold-off so that the output register fills and
    // the block refuses further requests for a while.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned mode;
        i_ready       <= 1'b0;
        hold_off_done = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_off_go && !hold_off_done) begin
                hold_off_done = 1'b1;
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else begin
                mode = $urandom_range(0, 3);
                repeat ($urandom_range(8, 60)) begin
                    case (mode)
                        0:       i_ready <= 1'b1;
                        1:       i_ready <= 1'($urandom);
                        2:       i_ready <= ($urandom_range(0, 3) == 0);
                        default: i_ready <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Every result taken by the receiver is checked against the oldest
    // expectation. Outputs are read at the edge, before the block updates them.
    always @(posedge i_clk) begin : result_watch
        axis_report_t got;
        if (i_rst_n && o_valid && i_ready) begin
            got.coil   = o_coil_drive;
            got.busy   = o_homing_busy;
            got.pos[0] = o_position_a;
            got.pos[1] = o_position_b;
            got.pos[2] = o_position_c;
            got.pos[3] = o_position_d;
            sb.check_result(got);
        end
    end

    // Watchdog: too long without any request moving on either channel means
    // the block has hung.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timed out after %0d cycles with no request moving", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial idle_cycles = 0;

endmodule

// ----- files.f -----
rtl/qhssp_pkg.sv
rtl/qhssp_lane.sv
rtl/qhssp_home.sv
rtl/quad_half_step_stepper_positioner_top.sv
rtl/qhssp_checker.sv
bench/qhssp_positioner_scoreboard_pkg.sv
bench/quad_half_step_stepper_positioner_top_test.sv
